>>> src/lubr_pkg.sv
// shared constants for the longest unique byte run block
// no dependencies; imported by longest_unique_byte_run
`timescale 1ns / 1ps

package lubr_pkg;

   localparam int BYTE_W      = 8;
   localparam int BYTE_VALUES = 256;
   localparam int LEN_W       = 17;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   localparam int MAX_LEN_DEF = 65536;
   localparam int SYMBOLS_DEF = 256;

endpackage

>>> src/lubr_seen_ram.sv
// last-seen position table: one write port, one registered read port
// no dependencies; instantiated by longest_unique_byte_run
`timescale 1ns / 1ps

module lubr_seen_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/longest_unique_byte_run.sv
// Takes one byte per beat (req_tlast on the final byte of a string) and, on the
// final byte, returns the length of the longest run of distinct bytes, with an
// overflow flag when the string ran past MAX_LEN bytes (bytes beyond that are
// ignored). One byte is accepted every cycle while the input does not stall; the
// final byte is registered in stage s1 and its result in the output register.
// The rate is set by the last-seen table, a synchronous memory read in the accept
// cycle and written back when an in-range byte leaves s1, with the previous write
// forwarded. Per-symbol valid bits clear at the end of each string, so strings
// follow each other without a gap. Input stalls only while a result waits in the
// output register and another final byte is ready to complete.
// depends on lubr_pkg and lubr_seen_ram
`timescale 1ns / 1ps

module longest_unique_byte_run import lubr_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF,
   parameter int SYMBOLS = SYMBOLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] byte_value
   input  logic                   req_tlast,  // last_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [16:0] longest_length, zero fill above
   output logic                   rsp_tuser   // overflow
);

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int SYM_W = $clog2(SYMBOLS);

   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] sym;
      logic             last;
   } stage_type;

   logic [SYM_W-1:0] sym_lut [BYTE_VALUES];

   for (genvar g = 0; g < BYTE_VALUES; g++) begin : g_sym_lut
      assign sym_lut[g] = SYM_W'(g % SYMBOLS);
   end

   stage_type          s1_ff, s1_in;
   logic [SYM_W-1:0]   fwd_sym_ff;
   logic [IDX_W-1:0]   fwd_pos_ff;
   logic [POS_W-1:0]   ws_ff, ws_in;
   logic [POS_W-1:0]   best_ff, best_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               too_long_ff, too_long_in;
   logic [SYMBOLS-1:0] seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]   rsp_len_ff;
   logic               rsp_ovf_ff;

   logic               req_fire;
   logic               out_free;
   logic               s1_fire;
   logic               end_fire;
   logic [SYM_W-1:0]   req_sym;
   logic [IDX_W-1:0]   ram_rd_data;
   logic [IDX_W-1:0]   prev_pos;
   logic               hit;
   logic               in_range;
   logic               wr_en;
   logic [POS_W-1:0]   run_hit;
   logic [POS_W-1:0]   run_end;
   logic [POS_W-1:0]   best_end;
   logic               ovf_end;

   assign req_sym = sym_lut[req_tdata[BYTE_W-1:0]];

   lubr_seen_ram #(
      .DEPTH  (SYMBOLS),
      .ADDR_W (SYM_W),
      .DATA_W (IDX_W)
   ) u_seen_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_sym),
      .rd_data (ram_rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.sym),
      .wr_data (pos_ff[IDX_W-1:0])
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      s1_fire    = s1_ff.valid && (!s1_ff.last || out_free);
      end_fire   = s1_fire && s1_ff.last;
      req_tready = !s1_ff.valid || s1_fire;
      req_fire   = req_tvalid && req_tready;

      s1_in = s1_ff;
      if (req_fire) begin
         s1_in.valid = 1'b1;
         s1_in.sym   = req_sym;
         s1_in.last  = req_tlast;
      end else if (s1_fire) begin
         s1_in.valid = 1'b0;
      end

      // the read issued alongside the previous write misses it
      prev_pos = (fwd_sym_ff == s1_ff.sym) ? fwd_pos_ff : ram_rd_data;
      hit      = seen_ff[s1_ff.sym] && (POS_W'(prev_pos) >= ws_ff);
      in_range = pos_ff < POS_W'(MAX_LEN);
      run_hit  = pos_ff - ws_ff;

      ws_in       = ws_ff;
      best_in     = best_ff;
      pos_in      = pos_ff;
      too_long_in = too_long_ff;
      seen_in     = seen_ff;
      wr_en       = 1'b0;
      if (s1_fire) begin
         if (in_range) begin
            if (hit) begin
               if (run_hit > best_ff) begin
                  best_in = run_hit;
               end
               ws_in = POS_W'(prev_pos) + POS_W'(1);
            end
            seen_in[s1_ff.sym] = 1'b1;
            pos_in             = pos_ff + POS_W'(1);
            wr_en              = 1'b1;
         end else begin
            too_long_in = 1'b1;
         end
      end

      run_end  = pos_in - ws_in;
      best_end = (run_end > best_in) ? run_end : best_in;
      ovf_end  = too_long_in;

      if (end_fire) begin
         ws_in       = '0;
         best_in     = '0;
         pos_in      = '0;
         too_long_in = 1'b0;
         seen_in     = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (end_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         ws_ff        <= '0;
         best_ff      <= '0;
         pos_ff       <= '0;
         too_long_ff  <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         ws_ff        <= ws_in;
         best_ff      <= best_in;
         pos_ff       <= pos_in;
         too_long_ff  <= too_long_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_sym_ff <= s1_ff.sym;
         fwd_pos_ff <= pos_ff[IDX_W-1:0];
      end
      if (end_fire) begin
         rsp_len_ff <= LEN_W'(best_end);
         rsp_ovf_ff <= ovf_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_len_ff);
   assign rsp_tuser  = rsp_ovf_ff;

   a_ws_le_pos: assert property (@(posedge clock) disable iff (reset)
      ws_ff <= pos_ff)
      else $error("window start beyond byte position");

   a_ovf_at_max: assert property (@(posedge clock) disable iff (reset)
      too_long_ff |-> (pos_ff == POS_W'(MAX_LEN)))
      else $error("overflow flag set below maximum length");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> (pos_ff == '0) && (seen_ff == '0) && rsp_tvalid)
      else $error("string state not cleared after final byte");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (POS_W'(rsp_tdata[LEN_W-1:0]) <= POS_W'(MAX_LEN)))
      else $error("result length beyond maximum");

endmodule

>>> test/testbench.sv
// testbench for longest_unique_byte_run: streams strings of bytes with random gaps and
// result back-pressure, predicts the longest distinct-byte run of each string and checks it
// depends on lubr_pkg and longest_unique_byte_run
`timescale 1ns / 1ps

module testbench;
   import lubr_pkg::*;

   localparam int MAX_LEN     = MAX_LEN_DEF;
   localparam int SYMBOLS     = SYMBOLS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_BYTES = 700;
   localparam int LONG_HOLD   = 300;

   typedef struct {
      logic [BYTE_W-1:0] value;
      bit                is_last;
      int                gap;
      bit                drain;
   } byte_beat_type;

   typedef struct {
      logic [LEN_W-1:0] length;
      logic             overflow;
   } run_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // [7:0] byte_value
   logic                   req_tlast = 1'b0;  // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // [16:0] longest_length, zero fill above
   logic                   rsp_tuser;  // overflow

   byte_beat_type  pending_q[$];
   run_result_type run_length_q[$];

   bit          seen_ok[BYTE_VALUES];
   int unsigned seen_at[BYTE_VALUES];
   int unsigned win_start = 0;
   int unsigned best_run = 0;
   int unsigned str_pos = 0;
   bit          str_too_long = 1'b0;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int results_seen = 0;
   int fail_count = 0;
   int cycle_count = 0;

   int idle_left = 0;
   bit gap_served = 1'b0;
   int hold_left = 0;
   bit rsp_started = 1'b0;

   longest_unique_byte_run #(
      .MAX_LEN(MAX_LEN),
      .SYMBOLS(SYMBOLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic void clear_run_state();
      foreach (seen_ok[s]) begin
         seen_ok[s] = 1'b0;
         seen_at[s] = 0;
      end
      win_start = 0;
      best_run = 0;
      str_pos = 0;
      str_too_long = 1'b0;
   endfunction

   function automatic void track_unique_run(logic [BYTE_W-1:0] value, logic is_last);
      int unsigned sym;
      int unsigned run;
      int unsigned best;
      run_result_type res;
      sym = int'(value) % SYMBOLS;
      if (str_pos >= MAX_LEN) begin
         str_too_long = 1'b1;
      end else begin
         if (seen_ok[sym] && seen_at[sym] >= win_start) begin
            run = str_pos - win_start;
            if (run > best_run) best_run = run;
            win_start = seen_at[sym] + 1;
         end
         seen_at[sym] = str_pos;
         seen_ok[sym] = 1'b1;
         str_pos = str_pos + 1;
      end
      if (is_last) begin
         run = str_pos - win_start;
         best = (run > best_run) ? run : best_run;
         res.length = LEN_W'(best);
         res.overflow = str_too_long;
         run_length_q.push_back(res);
         clear_run_state();
      end
   endfunction

   function automatic void queue_byte(logic [BYTE_W-1:0] value, bit is_last, int gap, bit drain);
      byte_beat_type beat;
      beat.value = value;
      beat.is_last = is_last;
      beat.gap = gap;
      beat.drain = drain;
      pending_q.push_back(beat);
   endfunction

   function automatic void queue_text(string text);
      for (int i = 0; i < text.len(); i++)
         queue_byte(text[i], i == text.len() - 1, $urandom_range(0, 19), 1'b0);
   endfunction

   // sampling side: acceptance, prediction and result check
   always @(posedge clock) begin
      run_result_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) track_unique_run(req_tdata[BYTE_W-1:0], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (run_length_q.size() == 0) begin
            $display("%0t: unexpected result beat, length %0d overflow %0d",
                     $time, rsp_tdata[LEN_W-1:0], rsp_tuser);
            fail_count++;
         end else begin
            want = run_length_q.pop_front();
            if (rsp_tdata[LEN_W-1:0] !== want.length) begin
               $display("%0t: longest_length expected %0d, got %0d",
                        $time, want.length, rsp_tdata[LEN_W-1:0]);
               fail_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $display("%0t: overflow expected %0d, got %0d", $time, want.overflow, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // byte source
   always @(negedge clock) begin
      byte_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (idle_left > 0) begin
            idle_left--;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!gap_served && pending_q[0].gap > 0) begin
            idle_left = pending_q[0].gap - 1;
            gap_served = 1'b1;
            req_tvalid <= 1'b0;
         end else if (pending_q[0].drain && run_length_q.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            beat = pending_q.pop_front();
            gap_served = 1'b0;
            req_tvalid <= 1'b1;
            req_tdata <= beat.value;
            req_tlast <= beat.is_last;
         end
      end
   end

   // result sink
   always @(negedge clock) begin
      int wait_cycles;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_taken || !rsp_started) begin
         rsp_started = 1'b1;
         if (results_seen == 3)
            wait_cycles = LONG_HOLD;
         else if ((results_seen / 16) % 4 == 2)
            wait_cycles = 0;
         else
            wait_cycles = $urandom_range(0, 19);
         if (wait_cycles > 0) begin
            hold_left = wait_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[longest_unique_byte_run] ERROR");
         $finish;
      end
   end

   initial begin
      logic [BYTE_W-1:0] perm[BYTE_VALUES];
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] base;
      int kind, len, span, gap, j, random_count, strings_made;
      bit quiet, drain;

      clear_run_state();

      // short directed strings
      queue_byte(8'h00, 1'b1, 0, 1'b0);
      queue_byte(8'hff, 1'b1, 3, 1'b0);
      queue_byte(8'h80, 1'b1, 0, 1'b0);
      queue_text("aa");
      queue_text("abba");
      queue_text("dvdf");
      queue_byte(8'h00, 1'b0, 2, 1'b0);
      queue_byte(8'hff, 1'b0, 0, 1'b0);
      queue_byte(8'h00, 1'b1, 0, 1'b0);
      queue_text("pwwkew");

      random_count = 0;
      strings_made = 0;
      while (random_count < RANDOM_BYTES) begin
         kind = $urandom_range(0, 19);
         quiet = (strings_made % 10) >= 7;
         drain = $urandom_range(0, 14) == 0;
         base = BYTE_W'($urandom_range(0, 255));
         span = $urandom_range(1, 12);
         if (kind == 0) begin
            for (int i = 0; i < BYTE_VALUES; i++) perm[i] = BYTE_W'(i);
            for (int i = BYTE_VALUES - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            len = $urandom_range(240, 280);
         end else begin
            len = $urandom_range(1, 24);
         end
         if (len > RANDOM_BYTES - random_count) len = RANDOM_BYTES - random_count;
         for (int i = 0; i < len; i++) begin
            gap = quiet ? 0 : $urandom_range(0, 19);
            if (kind == 0)
               tmp = (i < BYTE_VALUES) ? perm[i] : BYTE_W'($urandom_range(0, 255));
            else if (kind <= 9)
               tmp = BYTE_W'(base + $urandom_range(0, span - 1));
            else
               tmp = BYTE_W'($urandom_range(0, 255));
            queue_byte(tmp, i == len - 1, gap, drain && i == 0);
         end
         random_count += len;
         strings_made++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (run_length_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[longest_unique_byte_run] OK");
      else
         $display("[longest_unique_byte_run] ERROR");
      $finish;
   end

endmodule

>>> sim.f
src/lubr_pkg.sv
src/lubr_seen_ram.sv
src/longest_unique_byte_run.sv
test/testbench.sv
